[hdl/smtee_pkg.sv]
// shared types and constants for the sorted timer expiry engine
package smtee_pkg;

    localparam int          SLOT_W   = 6;
    localparam int          MAX_OUT  = 32;
    localparam logic [31:0] DL_NEVER = 32'hffff_ffff;

    typedef enum logic [2:0] {
        FN_ALLOC = 3'd0,
        FN_FREE  = 3'd1,
        FN_BIND  = 3'd2,
        FN_ARM   = 3'd3,
        FN_TICK  = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        KD_GRANT   = 2'd0,
        KD_NONE    = 2'd1,
        KD_EXPIRED = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_ALLOC = 2'd1,
        ST_ARMED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHK,
        S_BUBBLE,
        S_PLACE,
        S_TREAD,
        S_EMIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_MARK,
        CELL_BUBBLE,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        logic              valid;
        logic              del;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       dl;
    } t_entry;

    typedef struct packed {
        t_cell_op          op;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       dl;
    } t_cell_ctrl;

    localparam t_entry ENTRY_EMPTY = '{valid: 1'b0, del: 1'b0, slot: '0, dl: DL_NEVER};

endpackage

[hdl/smtee_if.sv]
// transaction channels for operations and results
interface smtee_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [4:0]         slot;
    logic [3:0]         channel;
    logic signed [31:0] message;
    logic [31:0]        delay;

    modport source (output valid, func, slot, channel, message, delay, input ready);
    modport sink   (input valid, func, slot, channel, message, delay, output ready);
endinterface

interface smtee_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [4:0]         slot_out;
    logic [3:0]         channel_out;
    logic signed [31:0] message_out;
    logic               last;

    modport source (output valid, kind, slot_out, channel_out, message_out, last, input ready);
    modport sink   (input valid, kind, slot_out, channel_out, message_out, last, output ready);
endinterface

[hdl/smtee_cell.sv]
// one cell of the deadline-ordered chain of armed timers
module smtee_cell
    import smtee_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_left,
    input  logic       i_left_ge,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_ge
);

    t_entry r_entry;
    t_entry n_entry;

    // new deadline goes before this cell
    assign o_ge    = !r_entry.valid || (i_ctrl.dl <= r_entry.dl);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.op)
            CELL_INSERT: begin
                if (o_ge) begin
                    if (i_left_ge) begin
                        n_entry = i_left;
                    end else begin
                        n_entry.valid = 1'b1;
                        n_entry.del   = 1'b0;
                        n_entry.slot  = i_ctrl.slot;
                        n_entry.dl    = i_ctrl.dl;
                    end
                end
            end
            CELL_MARK: begin
                n_entry.del = r_entry.valid && (r_entry.slot == i_ctrl.slot);
                if (n_entry.del) begin
                    n_entry.valid = 1'b0;
                end
            end
            CELL_BUBBLE: begin
                if (r_entry.del) begin
                    n_entry = i_right;
                end else if (i_left.del) begin
                    n_entry = i_left;
                end
            end
            CELL_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_entry.del   <= 1'b0;
            r_entry.slot  <= '0;
            r_entry.dl    <= DL_NEVER;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

[hdl/sorted_multi_timer_expiry_engine_unit.sv]
// top level of the sorted timer expiry engine
// One transaction is taken at a time. Bind writes the store on acceptance; alloc scans the slots
// (the free-slot scan reads one status per cycle) and then gives its result on a handshake; free
// and arm check the slot status and then place, and for an armed slot bubble first (the removed
// entry moves one cell per cycle to the tail of the chain); a tick reads the chain head and emits
// each expired timer on a result handshake (channel and message come from a memory with a registered read port).
module sorted_multi_timer_expiry_engine_unit
    import smtee_pkg::*;
#(
    parameter int TIMER_SLOTS = 32,
    parameter int CHANNELS    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    smtee_in_if.sink     i_in,
    smtee_out_if.source  o_out
);

    localparam int IW = $clog2(TIMER_SLOTS);

    t_state             r_state;
    t_state             n_state;
    t_func              r_func;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_cnt;
    logic [31:0]        r_count;
    logic [31:0]        r_dl;
    logic [5:0]         r_n;
    t_kind              r_kind;
    logic               r_last;
    t_status            r_status [TIMER_SLOTS];
    logic [3:0]         r_mem_chan [TIMER_SLOTS];
    logic signed [31:0] r_mem_msg [TIMER_SLOTS];
    logic [3:0]         r_rd_chan;
    logic signed [31:0] r_rd_msg;

    t_cell_ctrl         w_ctrl;
    t_entry             w_entry [TIMER_SLOTS];
    logic               w_ge [TIMER_SLOTS];
    logic               w_acc;
    logic               w_slot_ok;
    logic               w_chan_ok;
    logic               w_exp0;
    logic               w_exp1;
    logic [IW-1:0]      w_head;
    t_status            w_cur;

    assign w_acc     = i_in.valid && i_in.ready;
    assign w_slot_ok = (32'(i_in.slot) < TIMER_SLOTS);
    assign w_chan_ok = (32'(i_in.channel) < CHANNELS);
    assign w_head    = IW'(w_entry[0].slot);
    assign w_cur     = r_status[r_idx];
    assign w_exp0    = w_entry[0].valid && (w_entry[0].dl <= r_count)
                       && (r_n < 6'(MAX_OUT));
    assign w_exp1    = w_entry[1].valid && (w_entry[1].dl <= r_count)
                       && (r_n < 6'(MAX_OUT - 1));

    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_left_ge;
            if (g == 0) begin : g_first
                assign w_left    = ENTRY_EMPTY;
                assign w_left_ge = 1'b0;
            end else begin : g_mid
                assign w_left    = w_entry[g-1];
                assign w_left_ge = w_ge[g-1];
            end
            if (g == TIMER_SLOTS - 1) begin : g_last
                assign w_right = ENTRY_EMPTY;
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end
            smtee_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (w_ctrl),
                .i_left    (w_left),
                .i_left_ge (w_left_ge),
                .i_right   (w_right),
                .o_entry   (w_entry[g]),
                .o_ge      (w_ge[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    priority case (i_in.func)
                        FN_ALLOC: n_state = S_SCAN;
                        FN_FREE, FN_ARM: n_state = w_slot_ok ? S_CHK : S_IDLE;
                        FN_TICK:  n_state = S_TREAD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_cur == ST_FREE || r_idx == IW'(TIMER_SLOTS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_CHK:    n_state = (w_cur == ST_ARMED) ? S_BUBBLE : S_PLACE;
            S_BUBBLE: n_state = (r_cnt == IW'(TIMER_SLOTS - 2)) ? S_PLACE : S_BUBBLE;
            S_PLACE:  n_state = S_IDLE;
            S_TREAD:  n_state = w_exp0 ? S_EMIT : S_IDLE;
            S_EMIT: begin
                if (o_out.ready) begin
                    n_state = r_last ? S_IDLE : S_TREAD;
                end
            end
            S_OUT:    n_state = o_out.ready ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs and cell control
    always_comb begin
        i_in.ready  = (r_state == S_IDLE);
        o_out.valid = (r_state == S_EMIT) || (r_state == S_OUT);
        w_ctrl.op   = CELL_HOLD;
        w_ctrl.slot = SLOT_W'(r_idx);
        w_ctrl.dl   = r_dl;
        unique case (r_state)
            S_CHK:    w_ctrl.op = (w_cur == ST_ARMED) ? CELL_MARK : CELL_HOLD;
            S_BUBBLE: w_ctrl.op = CELL_BUBBLE;
            S_PLACE:  w_ctrl.op = (r_func == FN_ARM) ? CELL_INSERT : CELL_HOLD;
            S_EMIT:   w_ctrl.op = o_out.ready ? CELL_POP : CELL_HOLD;
            default:  w_ctrl.op = CELL_HOLD;
        endcase
    end

    assign o_out.kind        = r_kind;
    assign o_out.slot_out    = (r_kind == KD_NONE) ? 5'd0 : 5'(r_idx);
    assign o_out.channel_out = (r_kind == KD_EXPIRED) ? r_rd_chan : 4'd0;
    assign o_out.message_out = (r_kind == KD_EXPIRED) ? r_rd_msg : 32'sd0;
    assign o_out.last        = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            for (int k = 0; k < TIMER_SLOTS; k++) begin
                r_status[k] <= ST_FREE;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_func <= t_func'(i_in.func);
                        r_idx  <= (i_in.func == FN_ALLOC) ? '0 : IW'(i_in.slot);
                        r_dl   <= r_count + i_in.delay;
                        r_cnt  <= '0;
                        r_n    <= '0;
                        if (i_in.func == FN_TICK) begin
                            r_count <= r_count + 32'd1;
                        end
                    end
                end
                S_SCAN: begin
                    r_last <= 1'b1;
                    if (w_cur == ST_FREE) begin
                        r_status[r_idx] <= ST_ALLOC;
                        r_kind          <= KD_GRANT;
                    end else if (r_idx == IW'(TIMER_SLOTS - 1)) begin
                        r_kind <= KD_NONE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_BUBBLE: r_cnt <= r_cnt + IW'(1);
                S_PLACE: begin
                    r_status[r_idx] <= (r_func == FN_ARM) ? ST_ARMED : ST_FREE;
                end
                S_TREAD: begin
                    if (w_exp0) begin
                        r_idx  <= w_head;
                        r_kind <= KD_EXPIRED;
                        r_last <= !w_exp1;
                    end
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        r_status[r_idx] <= ST_ALLOC;
                        r_n             <= r_n + 6'd1;
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // channel and message store
    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.func == FN_BIND && w_slot_ok && w_chan_ok) begin
            r_mem_chan[IW'(i_in.slot)] <= i_in.channel;
            r_mem_msg[IW'(i_in.slot)]  <= i_in.message;
        end
        if (r_state == S_TREAD) begin
            r_rd_chan <= r_mem_chan[w_head];
            r_rd_msg  <= r_mem_msg[w_head];
        end
    end

endmodule
